// ===== rtl/core/rme_pkg.sv =====
// register machine execute package: request and response types, opcodes,
// register file and program counter sizes; no dependencies
`default_nettype none

package rme_pkg;

    localparam int REG_COUNT = 40;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int REG_IDX_W = 6;
    localparam int PC_W      = 16;

    localparam logic [4:0] OP_DISPLAY   = 5'd0;
    localparam logic [4:0] OP_GEN       = 5'd1;
    localparam logic [4:0] OP_BR        = 5'd2;
    localparam logic [4:0] OP_SWAP      = 5'd3;
    localparam logic [4:0] OP_SEXT      = 5'd4;
    localparam logic [4:0] OP_XOR       = 5'd5;
    localparam logic [4:0] OP_MUL       = 5'd6;
    localparam logic [4:0] OP_ADD       = 5'd7;
    localparam logic [4:0] OP_ELEMADDR  = 5'd8;
    localparam logic [4:0] OP_PIXEL     = 5'd9;
    localparam logic [4:0] OP_SEL       = 5'd10;
    localparam logic [4:0] OP_OR        = 5'd11;
    localparam logic [4:0] OP_MULI      = 5'd12;
    localparam logic [4:0] OP_INCEQ     = 5'd13;
    localparam logic [4:0] OP_ADDI      = 5'd14;
    localparam logic [4:0] OP_ELEMADDRI = 5'd15;
    localparam logic [4:0] OP_MODI      = 5'd16;
    localparam logic [4:0] OP_EQI       = 5'd17;
    localparam logic [4:0] OP_BRCOND    = 5'd18;

    typedef struct packed {
        logic [4:0]           op;
        logic [REG_IDX_W-1:0] reg_a;
        logic [REG_IDX_W-1:0] reg_b;
        logic [REG_IDX_W-1:0] reg_c;
        logic signed [63:0]   imm;
        logic [15:0]          target_true;
        logic [15:0]          target_false;
        logic signed [63:0]   gen_value;
    } t_req;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               display_req;
        logic               pixel_req;
        logic signed [63:0] pixel_x;
        logic signed [63:0] pixel_y;
        logic signed [63:0] pixel_color;
        logic               div_fault;
    } t_rsp;

    function automatic logic idx_ok(input logic [REG_IDX_W-1:0] idx);
        return 32'(idx) < REG_COUNT;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/register_machine_execute_top.sv =====
// register machine execute top level: sequencer, register file memory,
// shared 32x32 multiplier and shift-subtract remainder unit; uses rme_pkg
`default_nettype none

// Executes one decoded instruction per request against a 40-entry 64-bit
// register file (all zero after reset, tracked by per-entry valid bits) and a
// 16-bit program counter (1 after reset), returning one response per request.
// A request is taken only while the block is idle and sees the register file
// through a single registered read port, one operand per cycle. Simple
// operations pass through the read, ALU and two write states; multiplies form
// three 32x32 partial products through one shared multiplier, and remainders
// run the shift-subtract unit at one quotient bit per cycle; a zero divisor
// skips the divide. A finished response waits in the output register while
// the next request is accepted.
module register_machine_execute_top
    import rme_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_req i_in,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_rsp o_out
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_RC   = 4'd3;
    localparam logic [3:0] S_ALU  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_WR1  = 4'd7;
    localparam logic [3:0] S_WR2  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]           r_state;
    t_req                 r_req;
    t_rsp                 r_rsp;
    t_rsp                 r_out;
    logic                 r_out_valid;
    logic [PC_W-1:0]      r_pc;

    logic [63:0]          mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [63:0]          r_rd_data;
    logic                 r_rd_ok;
    logic [REG_IDX_W-1:0] rd_idx;
    logic [63:0]          rd_val;

    logic [63:0]          r_va;
    logic [63:0]          r_vb;
    logic [63:0]          r_vc;
    logic [63:0]          r_y;

    logic                 r_w1_en;
    logic [REG_IDX_W-1:0] r_w1_idx;
    logic [63:0]          r_w1_data;
    logic                 r_w2_en;
    logic [REG_IDX_W-1:0] r_w2_idx;
    logic [63:0]          r_w2_data;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [63:0]          wr_data;

    logic [5:0]           r_cnt;
    logic [63:0]          r_prod;
    logic [63:0]          r_acc;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          mul_p;

    logic [63:0]          r_num;
    logic [63:0]          r_den;
    logic [63:0]          r_rem;
    logic [64:0]          div_shift;
    logic [64:0]          div_trial;

    logic [63:0]          add_b;
    logic [63:0]          add_sum;
    logic [63:0]          inc_back;
    logic                 accept;
    logic                 out_free;
    logic                 mod_zero;
    logic [PC_W-1:0]      pc_inc;
    logic [PC_W-1:0]      pc_sel;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pc_inc      = r_pc + PC_W'(1);
    assign mod_zero    = (r_req.op == OP_MODI) && (r_req.imm == 64'sd0);

    assign pc_sel = (r_req.op == OP_BR) ? PC_W'(r_req.target_true)
                  : (r_req.op != OP_BRCOND) ? pc_inc
                  : (r_va == 64'd1) ? PC_W'(r_req.target_true)
                  : PC_W'(r_req.target_false);

    // register file read port, one operand per cycle
    always_comb begin
        unique case (r_state)
            S_RA:    rd_idx = r_req.reg_b;
            S_RB:    rd_idx = r_req.reg_c;
            default: rd_idx = i_in.reg_a;
        endcase
    end

    assign rd_val = r_rd_ok ? r_rd_data : 64'd0;

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_w1_idx;
        wr_data = r_w1_data;
        if (r_state == S_WR1) begin
            wr_en = r_w1_en && idx_ok(r_w1_idx);
        end else if (r_state == S_WR2) begin
            wr_en   = r_w2_en && idx_ok(r_w2_idx);
            wr_idx  = r_w2_idx;
            wr_data = r_w2_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx[REG_AW-1:0]] <= wr_data;
        end
        r_rd_data <= mem[rd_idx[REG_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_idx[REG_AW-1:0]] <= 1'b1;
            end
            r_rd_ok <= idx_ok(rd_idx) && r_vld[rd_idx[REG_AW-1:0]];
        end
    end

    // shared multiplier, operand halves picked by step
    always_comb begin
        case (r_cnt[1:0])
            2'd1: begin
                mul_a = r_vb[31:0];
                mul_b = r_y[63:32];
            end
            2'd2: begin
                mul_a = r_vb[63:32];
                mul_b = r_y[31:0];
            end
            default: begin
                mul_a = r_vb[31:0];
                mul_b = r_y[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // remainder step
    assign div_shift = {r_rem, r_num[63]};
    assign div_trial = div_shift - {1'b0, r_den};

    // shared adder
    always_comb begin
        case (r_req.op)
            OP_ELEMADDR:  add_b = {r_vc[60:0], 3'b000};
            OP_ADDI:      add_b = r_req.imm;
            OP_ELEMADDRI: add_b = {r_req.imm[60:0], 3'b000};
            OP_INCEQ:     add_b = 64'd1;
            default:      add_b = r_vc;
        endcase
    end

    assign add_sum = r_vb + add_b;

    // incremented register read back, zero when outside the file
    assign inc_back = idx_ok(r_req.reg_b) ? add_sum : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pc        <= PC_W'(1);
        end else begin
            r_out_valid <= ((r_state == S_DONE) && out_free) || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req   <= i_in;
                        r_state <= S_RA;
                    end
                end
                S_RA: begin
                    r_va    <= rd_val;
                    r_state <= S_RB;
                end
                S_RB: begin
                    r_vb    <= rd_val;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_vc                <= rd_val;
                    r_w1_en             <= mod_zero;
                    r_w2_en             <= 1'b0;
                    r_w1_idx            <= r_req.reg_a;
                    r_cnt               <= '0;
                    r_rsp.next_pc       <= 16'(pc_sel);
                    r_rsp.display_req   <= (r_req.op == OP_DISPLAY);
                    r_rsp.pixel_req     <= (r_req.op == OP_PIXEL);
                    r_rsp.pixel_x       <= (r_req.op == OP_PIXEL) ? r_va : '0;
                    r_rsp.pixel_y       <= (r_req.op == OP_PIXEL) ? r_vb : '0;
                    r_rsp.pixel_color   <= (r_req.op == OP_PIXEL) ? rd_val : '0;
                    r_rsp.div_fault     <= mod_zero;
                    r_y                 <= (r_req.op == OP_MULI) ? r_req.imm : rd_val;
                    if (r_req.op inside {OP_MUL, OP_MULI}) begin
                        r_state <= S_MUL;
                    end else if (mod_zero) begin
                        r_w1_data <= '0;
                        r_state   <= S_WR1;
                    end else if (r_req.op == OP_MODI) begin
                        r_num   <= mag64(r_vb);
                        r_den   <= mag64(r_req.imm);
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    r_w1_en <= r_req.op inside {OP_GEN, OP_SWAP, OP_SEXT, OP_XOR, OP_OR,
                                                OP_SEL, OP_EQI, OP_INCEQ, OP_ADD,
                                                OP_ELEMADDR, OP_ADDI, OP_ELEMADDRI};
                    case (r_req.op) inside
                        OP_GEN:  r_w1_data <= r_req.gen_value;
                        OP_SWAP: begin
                            r_w1_data <= r_vb;
                            r_w2_en   <= 1'b1;
                            r_w2_idx  <= r_req.reg_b;
                            r_w2_data <= r_va;
                        end
                        OP_SEXT: r_w1_data <= (r_vb == 64'd1) ? '1 : '0;
                        OP_XOR:  r_w1_data <= r_vb ^ r_vc;
                        OP_OR:   r_w1_data <= r_vb | r_vc;
                        OP_SEL:  r_w1_data <= (r_vb == 64'd1) ? r_vc : '0;
                        OP_EQI:  r_w1_data <= {63'd0, r_vb == r_req.imm};
                        OP_INCEQ: begin
                            // incremented register goes first, compare result last
                            r_w1_idx  <= r_req.reg_b;
                            r_w1_data <= add_sum;
                            r_w2_en   <= 1'b1;
                            r_w2_idx  <= r_req.reg_a;
                            r_w2_data <= {63'd0, inc_back == r_req.imm};
                        end
                        OP_ADD, OP_ELEMADDR, OP_ADDI, OP_ELEMADDRI: begin
                            r_w1_data <= add_sum;
                        end
                        default: ;
                    endcase
                    r_state <= S_WR1;
                end
                S_MUL: begin
                    r_prod <= mul_p;
                    r_cnt  <= r_cnt + 6'd1;
                    case (r_cnt[1:0])
                        2'd0: ;
                        2'd1: r_acc <= r_prod;
                        2'd2: r_acc <= r_acc + {r_prod[31:0], 32'd0};
                        default: begin
                            r_w1_en   <= 1'b1;
                            r_w1_data <= r_acc + {r_prod[31:0], 32'd0};
                            r_state   <= S_WR1;
                        end
                    endcase
                end
                S_DIV: begin
                    r_num <= {r_num[62:0], 1'b0};
                    r_rem <= div_trial[64] ? div_shift[63:0] : div_trial[63:0];
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_w1_en   <= 1'b1;
                        r_w1_data <= div_trial[64] ? div_shift[63:0] : div_trial[63:0];
                        r_state   <= S_WR1;
                    end
                end
                S_WR1: begin
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= r_rsp;
                        r_pc    <= PC_W'(r_rsp.next_pc);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
